// File: hw/rtl/ilq_pkg.sv
// shared types and constants for the index linked queue
package ilq_pkg;

  localparam int SLOTS   = 64;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int FIELD_W = 6;
  localparam int VAL_W   = 8;
  localparam int POS_W   = 6;
  localparam int CFG_W   = 7;

  typedef enum logic [2:0] {
    KIND_CLEAR      = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_PUSH_BACK  = 3'd2,
    KIND_POP        = 3'd3,
    KIND_COUNT      = 3'd4,
    KIND_MAX        = 3'd5,
    KIND_LIST       = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_INDEX = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_SELF_LINK = 3'd3,
    STAT_BOUND     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic step;
    logic flush;
  } ilq_cmd_t;

  typedef struct packed {
    logic walk_start;
    logic step_end;
    logic step_flush;
    logic out_free;
  } ilq_stat_t;

endpackage

// File: hw/rtl/ilq_ram.sv
// generic single-port-write ram with registered read
module ilq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ilq_ctrl.sv
// control state machine for the index linked queue
module ilq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  ilq_pkg::ilq_stat_t stat,
  output ilq_pkg::ilq_cmd_t  cmd
);
  import ilq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = stat.walk_start ? S_WALK : S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat.out_free) begin
          if (stat.step_end) begin
            state_next = S_IDLE;
          end else if (stat.step_flush) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      S_EXEC:  cmd.exec  = stat.out_free;
      S_WALK:  cmd.step  = stat.out_free;
      S_FLUSH: cmd.flush = stat.out_free;
      default: cmd = '0;
    endcase
  end

  // only one datapath action per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.exec, cmd.step, cmd.flush}))
    else $error("more than one datapath command");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state != S_IDLE)
    else $error("accepted beat left controller idle");

  a_walk_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && !stat.out_free) |=> state == S_WALK)
    else $error("walk moved on while result stalled");

endmodule

// File: hw/rtl/ilq_dp.sv
// link store, head and tail, walk registers and result register
module ilq_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [7:0]                s_tdata,
  input  logic [2:0]                s_tuser,
  input  logic [ilq_pkg::CFG_W-1:0] slots_in_use,
  input  ilq_pkg::ilq_cmd_t         cmd,
  output ilq_pkg::ilq_stat_t        stat,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [23:0]               m_tdata,
  output logic                      m_tlast
);
  import ilq_pkg::*;

  // latched item
  kind_t              op;
  logic [FIELD_W-1:0] idx_f;
  logic [IDX_W-1:0]   idx;

  logic             head_vld, tail_vld;
  logic [IDX_W-1:0] head, tail;
  logic             head_vld_next, tail_vld_next;
  logic [IDX_W-1:0] head_next, tail_next;

  // one valid bit per link entry, an invalid entry reads as end of chain
  logic [SLOTS-1:0] lvalid;
  logic             lv_clr_all;
  logic             lv_set_en, lv_clr_en;
  logic [IDX_W-1:0] lv_set_addr, lv_clr_addr;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_wdata;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rdata;
  logic             rd_vld;

  // walk registers
  logic [IDX_W-1:0] cur, mx, pend, pend_pos;
  logic [CNT_W-1:0] n;
  logic             pend_vld;
  status_t          fin_status;

  logic [CNT_W-1:0] n1;
  logic [IDX_W-1:0] mx1;
  logic             self_link, walk_end;
  status_t          end_status;
  logic             reject;

  logic             out_load, out_free;
  status_t          out_status;
  logic [VAL_W-1:0] out_value;
  logic [POS_W-1:0] out_pos;
  logic             out_last, out_empty;

  logic [2:0]         r_status;
  logic [VAL_W-1:0]   r_value;
  logic [POS_W-1:0]   r_pos;
  logic               r_empty;

  assign idx = idx_f[IDX_W-1:0];

  ilq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign reject = ({1'b0, idx_f} >= slots_in_use) || (int'(idx_f) >= SLOTS);

  assign self_link  = rd_vld && (rdata == cur);
  assign n1         = n + 1'b1;
  assign mx1        = (cur > mx) ? cur : mx;
  assign walk_end   = !rd_vld || (n1 == CNT_W'(SLOTS));
  assign end_status = rd_vld ? STAT_BOUND : STAT_OK;

  assign out_free = !m_tvalid || m_tready;

  assign rd_en   = cmd.accept || (cmd.step && !self_link && !walk_end);
  assign rd_addr = cmd.accept ? head : rdata;

  always_comb begin
    stat.walk_start = ((s_tuser == KIND_COUNT) || (s_tuser == KIND_MAX) ||
                       (s_tuser == KIND_LIST)) && head_vld;
    stat.step_end   = self_link || (op != KIND_LIST && walk_end);
    stat.step_flush = !self_link && op == KIND_LIST && walk_end;
    stat.out_free   = out_free;
  end

  // single-result operations, walk steps and the final flush
  always_comb begin
    head_vld_next = head_vld;
    head_next     = head;
    tail_vld_next = tail_vld;
    tail_next     = tail;
    lv_clr_all    = 1'b0;
    lv_set_en     = 1'b0;
    lv_set_addr   = idx;
    lv_clr_en     = 1'b0;
    lv_clr_addr   = idx;
    ram_we        = 1'b0;
    ram_waddr     = idx;
    ram_wdata     = head;
    out_load      = 1'b0;
    out_status    = STAT_OK;
    out_value     = '0;
    out_pos       = '0;
    out_last      = 1'b1;
    out_empty     = !head_vld;

    if (cmd.exec) begin
      out_load = 1'b1;
      case (op)
        KIND_CLEAR: begin
          lv_clr_all    = 1'b1;
          head_vld_next = 1'b0;
          tail_vld_next = 1'b0;
          out_empty     = 1'b1;
        end
        KIND_PUSH_FRONT: begin
          if (reject) begin
            out_status = STAT_BAD_INDEX;
          end else begin
            if (!tail_vld) begin
              tail_vld_next = 1'b1;
              tail_next     = idx;
            end
            if (head_vld) begin
              ram_we    = 1'b1;
              lv_set_en = 1'b1;
            end else begin
              lv_clr_en = 1'b1;
            end
            head_vld_next = 1'b1;
            head_next     = idx;
            out_value     = VAL_W'(idx);
            out_empty     = 1'b0;
          end
        end
        KIND_PUSH_BACK: begin
          if (reject) begin
            out_status = STAT_BAD_INDEX;
          end else begin
            if (!head_vld) begin
              head_vld_next = 1'b1;
              head_next     = idx;
            end else begin
              ram_we      = 1'b1;
              ram_waddr   = tail;
              ram_wdata   = idx;
              lv_set_en   = 1'b1;
              lv_set_addr = tail;
            end
            // end mark on the new tail, wins over the set when tail equals index
            lv_clr_en     = 1'b1;
            tail_vld_next = 1'b1;
            tail_next     = idx;
            out_value     = VAL_W'(idx);
            out_empty     = 1'b0;
          end
        end
        KIND_POP: begin
          if (!head_vld) begin
            out_status = STAT_EMPTY;
            out_value  = '1;
          end else begin
            out_value     = VAL_W'(head);
            head_vld_next = rd_vld;
            head_next     = rdata;
            if (!rd_vld) begin
              tail_vld_next = 1'b0;
            end
            out_empty = !rd_vld;
          end
        end
        // walk kinds reach here only with nothing queued
        KIND_COUNT: out_status = STAT_OK;
        KIND_MAX, KIND_LIST: begin
          out_status = STAT_EMPTY;
          out_value  = '1;
        end
        default: out_status = STAT_OK;
      endcase
    end else if (cmd.step) begin
      if (self_link) begin
        out_load   = 1'b1;
        out_status = STAT_SELF_LINK;
        case (op)
          KIND_COUNT: out_value = VAL_W'(0) - VAL_W'(n);
          KIND_MAX:   out_value = VAL_W'(mx);
          default: begin
            if (pend_vld) begin
              out_value = VAL_W'(pend);
              out_pos   = POS_W'(pend_pos);
            end else begin
              out_value = '1;
            end
          end
        endcase
      end else if (op == KIND_LIST) begin
        out_load  = pend_vld;
        out_value = VAL_W'(pend);
        out_pos   = POS_W'(pend_pos);
        out_last  = 1'b0;
      end else if (walk_end) begin
        out_load   = 1'b1;
        out_status = end_status;
        out_value  = (op == KIND_COUNT) ? VAL_W'(n1) : VAL_W'(mx1);
      end
    end else if (cmd.flush) begin
      out_load   = 1'b1;
      out_status = fin_status;
      out_value  = VAL_W'(pend);
      out_pos    = POS_W'(pend_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= 1'b0;
      tail_vld <= 1'b0;
      lvalid   <= '0;
      pend_vld <= 1'b0;
      n        <= '0;
    end else begin
      head_vld <= head_vld_next;
      tail_vld <= tail_vld_next;
      if (lv_clr_all) begin
        lvalid <= '0;
      end else begin
        if (lv_set_en) begin
          lvalid[lv_set_addr] <= 1'b1;
        end
        if (lv_clr_en) begin
          lvalid[lv_clr_addr] <= 1'b0;
        end
      end
      if (cmd.accept) begin
        pend_vld <= 1'b0;
        n        <= '0;
      end else if (cmd.step && !self_link) begin
        n <= n1;
        if (op == KIND_LIST) begin
          pend_vld <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    tail <= tail_next;
    if (rd_en) begin
      rd_vld <= lvalid[rd_addr];
    end
    if (cmd.accept) begin
      op    <= kind_t'(s_tuser);
      idx_f <= s_tdata[FIELD_W-1:0];
      cur   <= head;
      mx    <= head;
    end else if (cmd.step && !self_link) begin
      cur      <= rdata;
      mx       <= mx1;
      pend     <= cur;
      pend_pos <= n[IDX_W-1:0];
      if (walk_end) begin
        fin_status <= end_status;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      r_status <= out_status;
      r_value  <= out_value;
      r_pos    <= out_pos;
      r_empty  <= out_empty;
      m_tlast  <= out_last;
    end
  end

  assign m_tdata = {6'b0, r_empty, r_pos, r_value, r_status};

  a_head_tail_agree: assert property (@(posedge clk) disable iff (rst)
    head_vld == tail_vld)
    else $error("head and tail disagree on empty queue");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(SLOTS))
    else $error("walk tally beyond capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before taken");

endmodule

// File: hw/rtl/index_linked_queue_top.sv
// index linked queue: config register, controller and datapath
// clear, push, pop and unknown kinds pass through the exec state and give one result each
// count, max and list walk the chain, one link read per cycle while the result register is free
// an item is accepted only when the previous one has finished; result stalls hold the walk
// single-result items: the link ram read of the head is issued on accept, the result loaded in exec
// reset clears the head and tail valid bits and every link valid bit at once; slots_in_use returns to 64
module index_linked_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // index[5:0]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[2:0], value[10:3], position[16:11], is_empty[17]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ilq_pkg::*;

  logic [CFG_W-1:0] slots_in_use;
  ilq_cmd_t         cmd;
  ilq_stat_t        stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CFG_W'(SLOTS);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      slots_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'b0 : {{(32 - CFG_W){1'b0}}, slots_in_use};

  ilq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .slots_in_use (slots_in_use),
    .cmd          (cmd),
    .stat         (stat),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

// File: sim/index_linked_queue_top_test.sv
// self-checking stream and register testbench for the index linked queue
module index_linked_queue_top_test;
  import ilq_pkg::*;

  localparam logic [2:0] KIND_UNDEF        = 3'd7;
  localparam logic [2:0] ADDR_SLOTS_IN_USE = 3'd0;
  localparam int ITEMS_PER_SETTING = 66;
  localparam int SETTLE_CYCLES     = 8;
  localparam int DRAIN_CYCLES      = 100;
  localparam int HOLD_AT           = 200;
  localparam int HOLD_CYCLES       = 250;
  localparam int QUIET_FROM        = 300;
  localparam int QUIET_TO          = 380;
  localparam int CYCLE_LIMIT       = 200000;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] index;
  } slot_op_t;

  typedef struct {
    status_t            status;
    logic signed [7:0]  value;
    logic [5:0]         position;
    logic               last;
    logic               is_empty;
  } slot_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // index[5:0]
  logic [2:0]  s_tuser = '0;   // kind[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // status[2:0], value[10:3], position[16:11], is_empty[17]
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // queue state as the block should hold it
  logic signed [6:0] next_slot [SLOTS];
  logic signed [6:0] head_slot;
  logic signed [6:0] tail_slot;
  logic [6:0]        slots_cfg = 7'd64;

  slot_op_t     ops_to_send[$];
  slot_result_t slot_results_due[$];

  int  beats_in = 0;
  int  beats_out = 0;
  int  errors = 0;
  int  settings_run = 0;
  int  bound_beats = 0;
  int  self_link_beats = 0;
  int  list_beats = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  beat_taken = 1'b0;

  index_linked_queue_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic slot_result_t make_result(status_t st, int val, int pos, logic fin);
    slot_result_t r;
    r.status   = st;
    r.value    = val[7:0];
    r.position = pos[5:0];
    r.last     = fin;
    r.is_empty = (head_slot < 0);
    return r;
  endfunction

  function automatic void apply_slot_op(logic [2:0] kind, logic [5:0] index);
    slot_result_t walk[$];
    int cap, idx, cur, nx, mx, n;
    status_t st;
    idx = index;
    cap = (slots_cfg < SLOTS) ? slots_cfg : SLOTS;
    case (kind)
      KIND_CLEAR: begin
        foreach (next_slot[s]) next_slot[s] = -1;
        head_slot = -1;
        tail_slot = -1;
        slot_results_due.push_back(make_result(STAT_OK, 0, 0, 1'b1));
      end
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (idx >= cap) begin
          slot_results_due.push_back(make_result(STAT_BAD_INDEX, 0, 0, 1'b1));
        end else begin
          if (kind == KIND_PUSH_FRONT) begin
            if (tail_slot < 0) tail_slot = idx;
            next_slot[idx] = head_slot;
            head_slot = idx;
          end else begin
            if (head_slot < 0) head_slot = idx;
            else if (tail_slot >= 0) next_slot[tail_slot] = idx;
            tail_slot = idx;
            next_slot[idx] = -1;
          end
          slot_results_due.push_back(make_result(STAT_OK, idx, 0, 1'b1));
        end
      end
      KIND_POP: begin
        if (head_slot < 0) begin
          slot_results_due.push_back(make_result(STAT_EMPTY, -1, 0, 1'b1));
        end else begin
          cur = head_slot;
          head_slot = next_slot[cur];
          if (head_slot < 0) tail_slot = -1;
          slot_results_due.push_back(make_result(STAT_OK, cur, 0, 1'b1));
        end
      end
      KIND_COUNT, KIND_MAX, KIND_LIST: begin
        if (head_slot < 0) begin
          if (kind == KIND_COUNT)
            slot_results_due.push_back(make_result(STAT_OK, 0, 0, 1'b1));
          else
            slot_results_due.push_back(make_result(STAT_EMPTY, -1, 0, 1'b1));
        end else begin
          cur = head_slot;
          mx  = cur;
          n   = 0;
          st  = STAT_OK;
          while (cur >= 0) begin
            if (n >= SLOTS) begin
              st = STAT_BOUND;
              break;
            end
            nx = next_slot[cur];
            // a slot naming itself ends the walk uncounted
            if (nx == cur) begin
              st = STAT_SELF_LINK;
              break;
            end
            if (cur > mx) mx = cur;
            if (kind == KIND_LIST) walk.push_back(make_result(STAT_OK, cur, n, 1'b0));
            n++;
            cur = nx;
          end
          if (kind == KIND_COUNT) begin
            slot_results_due.push_back(
              make_result(st, (st == STAT_SELF_LINK) ? -n : n, 0, 1'b1));
          end else if (kind == KIND_MAX) begin
            slot_results_due.push_back(make_result(st, mx, 0, 1'b1));
          end else if (walk.size() == 0) begin
            slot_results_due.push_back(make_result(st, -1, 0, 1'b1));
          end else begin
            walk[walk.size() - 1].status = st;
            walk[walk.size() - 1].last   = 1'b1;
            foreach (walk[w]) slot_results_due.push_back(walk[w]);
          end
        end
      end
      default: slot_results_due.push_back(make_result(STAT_OK, 0, 0, 1'b1));
    endcase
  endfunction

  function automatic slot_op_t random_op(int cap);
    slot_op_t op;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 22)      op.kind = KIND_PUSH_FRONT;
    else if (roll < 48) op.kind = KIND_PUSH_BACK;
    else if (roll < 64) op.kind = KIND_POP;
    else if (roll < 74) op.kind = KIND_COUNT;
    else if (roll < 81) op.kind = KIND_MAX;
    else if (roll < 91) op.kind = KIND_LIST;
    else if (roll < 96) op.kind = KIND_CLEAR;
    else                op.kind = KIND_UNDEF;
    // mostly indices the queue will take, some beyond the limit
    if (cap > 0 && $urandom_range(0, 9) < 8) op.index = 6'($urandom_range(0, cap - 1));
    else op.index = 6'($urandom_range(0, 63));
    return op;
  endfunction

  function automatic bit take_break();
    if (beats_in >= QUIET_FROM && beats_in < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  task automatic send(logic [2:0] kind, logic [5:0] index);
    ops_to_send.push_back('{kind, index});
  endtask

  task automatic wait_for_idle();
    while (rst || ops_to_send.size() != 0 || s_tvalid || slot_results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    if (errors <= 40)
      $display("mismatch on result beat %0d: %s is %0d, wanted %0d", beats_out, field, got, want);
  endtask

  // input beats are taken here and fed to the predictor
  always @(posedge clk) begin
    if (rst) begin
      foreach (next_slot[s]) next_slot[s] = -1;
      head_slot = -1;
      tail_slot = -1;
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        apply_slot_op(s_tuser, s_tdata[5:0]);
        beats_in++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || beat_taken) begin
      if (ops_to_send.size() != 0 && !take_break()) begin
        s_tvalid <= 1'b1;
        s_tuser  <= ops_to_send[0].kind;
        s_tdata  <= {2'b00, ops_to_send[0].index};
        void'(ops_to_send.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= (hold_left == 0) && !take_break();
  end

  always @(posedge clk) begin
    slot_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (slot_results_due.size() == 0) begin
        report_mismatch("unexpected beat, status", m_tdata[2:0], -1);
      end else begin
        e = slot_results_due.pop_front();
        if (m_tdata[2:0] !== e.status) report_mismatch("status", m_tdata[2:0], e.status);
        if ($signed(m_tdata[10:3]) !== e.value)
          report_mismatch("value", $signed(m_tdata[10:3]), e.value);
        if (m_tdata[16:11] !== e.position)
          report_mismatch("position", m_tdata[16:11], e.position);
        if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
        if (m_tdata[17] !== e.is_empty) report_mismatch("is_empty", m_tdata[17], e.is_empty);
        if (e.status == STAT_BOUND) bound_beats++;
        if (e.status == STAT_SELF_LINK) self_link_beats++;
        if (e.position != 0) list_beats++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", slot_results_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [6:0] settings [6];
    int cap;
    settings[0] = 7'd1;
    settings[1] = 7'd0;
    settings[2] = 7'd127;
    settings[3] = 7'($urandom_range(2, 63));
    settings[4] = 7'd64;
    settings[5] = 7'($urandom_range(0, 127));

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // empty queue on every walk and on pop
    send(KIND_POP, 6'd0);
    send(KIND_COUNT, 6'd0);
    send(KIND_MAX, 6'd0);
    send(KIND_LIST, 6'd0);
    // small chain with the index extremes
    send(KIND_PUSH_BACK, 6'd63);
    send(KIND_PUSH_BACK, 6'd0);
    send(KIND_PUSH_FRONT, 6'd5);
    send(KIND_LIST, 6'd0);
    send(KIND_MAX, 6'd0);
    send(KIND_COUNT, 6'd0);
    send(KIND_POP, 6'd0);
    // pushing the head again at the front makes it link to itself
    send(KIND_PUSH_FRONT, 6'd63);
    send(KIND_PUSH_FRONT, 6'd9);
    send(KIND_COUNT, 6'd0);
    send(KIND_MAX, 6'd0);
    send(KIND_LIST, 6'd0);
    send(KIND_CLEAR, 6'd0);
    send(KIND_PUSH_BACK, 6'd4);
    send(KIND_PUSH_FRONT, 6'd4);
    send(KIND_LIST, 6'd0);
    send(KIND_CLEAR, 6'd0);
    // two-slot loop runs the count and list walks into the bound
    send(KIND_PUSH_BACK, 6'd1);
    send(KIND_PUSH_BACK, 6'd2);
    send(KIND_PUSH_FRONT, 6'd2);
    send(KIND_COUNT, 6'd0);
    send(KIND_LIST, 6'd0);
    send(KIND_UNDEF, 6'd42);
    send(KIND_CLEAR, 6'd0);

    foreach (settings[p]) begin
      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clk);
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_SLOTS_IN_USE;
      pwdata  <= {25'd0, settings[p]};
      @(negedge clk) penable <= 1'b1;
      do @(posedge clk); while (!pready);
      slots_cfg = settings[p];
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_run++;
      cap = (settings[p] < SLOTS) ? settings[p] : SLOTS;
      repeat (ITEMS_PER_SETTING) ops_to_send.push_back(random_op(cap));
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d operations under %0d slot limits after the reset default, %0d result beats",
             beats_in, settings_run, beats_out);
    $display("listed beyond the head %0d times, %0d walk-bound and %0d self-link results",
             list_beats, bound_beats, self_link_beats);
    if (errors == 0 && slot_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
